// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertions on clk, held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// expr must never be true at a clock edge out of reset
`define ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, expr)

`endif

`endif

// ===== hw/rtl/cpobb_pkg.sv =====
// ----------------------------------------------------------------------------
// cpobb_pkg
// Types, widths and helpers for the closest-point-on-box pipeline.
// ----------------------------------------------------------------------------
package cpobb_pkg;

	localparam int COORD_BITS = 20;
	localparam int AXIS_BITS  = 16;
	localparam int AXIS_FRAC  = AXIS_BITS - 2;

	// point - center, one extra bit
	localparam int DIFF_BITS  = COORD_BITS + 1;
	// axis component times difference or distance
	localparam int PROD_BITS  = AXIS_BITS + DIFF_BITS;
	// sum of three products plus the scaled center
	localparam int ACC_BITS   = PROD_BITS + 2;
	// accumulator after rounding off the axis fraction
	localparam int RND_BITS   = ACC_BITS - AXIS_FRAC;
	// clamped distance lies within +/- half extent
	localparam int DIST_BITS  = COORD_BITS + 1;

	localparam int CFG_DATA_BITS = 3 * COORD_BITS;
	localparam int CFG_IDX_BITS  = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_BOX_CENTER = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_HALF_EXT   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_AXIS_ZERO  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_AXIS_ONE   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_AXIS_TWO   = 3'd4;

	localparam logic signed [RND_BITS-1:0] COORD_MAX =
		RND_BITS'((1 << (COORD_BITS - 1)) - 1);
	localparam logic signed [RND_BITS-1:0] COORD_MIN = -COORD_MAX - RND_BITS'(1);
	localparam logic signed [ACC_BITS-1:0] HALF_LSB  = ACC_BITS'(1 << (AXIS_FRAC - 1));

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [AXIS_BITS-1:0]  axis_comp_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_z;
		logic signed [COORD_BITS-1:0] point_y;
		logic signed [COORD_BITS-1:0] point_x;
	} point_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] nearest_z;
		logic signed [COORD_BITS-1:0] nearest_y;
		logic signed [COORD_BITS-1:0] nearest_x;
	} nearest_t;

	// element [0] sits in the low bits, matching the register packing
	typedef struct packed {
		coord_t [2:0]                center;
		coord_t [2:0]                half;
		axis_comp_t [2:0][2:0]       axis;
	} box_cfg_t;

	// add half an LSB, drop the axis fraction (floor)
	function automatic logic signed [RND_BITS-1:0] round_frac(
		input logic signed [ACC_BITS-1:0] v
	);
		logic signed [ACC_BITS-1:0] t;
		t = v + HALF_LSB;
		return $signed(t[ACC_BITS-1:AXIS_FRAC]);
	endfunction

endpackage

// ===== hw/rtl/cpobb_proj.sv =====
// ----------------------------------------------------------------------------
// cpobb_proj
// Projects the offset onto the three box axes and clamps to the half extents.
// Two stages: products (s2), sum/round/clamp (s3).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpobb_proj import cpobb_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  box_cfg_t                    box,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [DIFF_BITS-1:0] diff [3],
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [DIST_BITS-1:0] clamp_dist [3]
);

	logic                        valid_s2, valid_s3;
	logic                        en_s2, en_s3;
	logic signed [PROD_BITS-1:0] prod_s2 [3][3];
	logic signed [DIST_BITS-1:0] dist_s3 [3];

	logic signed [ACC_BITS-1:0]  dot [3];
	logic signed [RND_BITS-1:0]  rnd [3];
	logic signed [RND_BITS-1:0]  hpos [3];
	logic signed [RND_BITS-1:0]  hneg [3];
	logic signed [DIST_BITS-1:0] clamped [3];

	assign en_s3    = !valid_s3 || out_ready;
	assign en_s2    = !valid_s2 || en_s3;
	assign in_ready = en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s2)
				valid_s2 <= in_valid;
			if (en_s3)
				valid_s3 <= valid_s2;
		end
	end

	// one product per axis component
	always_ff @(posedge clk) begin
		if (en_s2 && in_valid) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s2[i][j] <= $signed(box.axis[i][j]) * diff[j];
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dot[i] = ACC_BITS'(prod_s2[i][0]) + ACC_BITS'(prod_s2[i][1])
				+ ACC_BITS'(prod_s2[i][2]);
			rnd[i] = round_frac(dot[i]);
			hpos[i] = $signed(RND_BITS'(box.half[i]));
			hneg[i] = -hpos[i];
			if (rnd[i] > hpos[i]) begin
				clamped[i] = hpos[i][DIST_BITS-1:0];
			end else if (rnd[i] < hneg[i]) begin
				clamped[i] = hneg[i][DIST_BITS-1:0];
			end else begin
				clamped[i] = rnd[i][DIST_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && valid_s2) begin
			for (int i = 0; i < 3; i++) begin
				dist_s3[i] <= clamped[i];
			end
		end
	end

	assign out_valid  = valid_s3;
	assign clamp_dist = dist_s3;

	// a held word in s3 must stay put and stay valid
	`ASSERT_CLK(a_proj_hold, valid_s3 && !out_ready |=> valid_s3 && $stable(dist_s3[0]))
	// clamped distance never exceeds the positive half extent along axis 0
	`ASSERT_NEVER(a_proj_clamp, valid_s3 && (RND_BITS'(dist_s3[0]) > hpos[0]))

endmodule

// ===== hw/rtl/cpobb_recon.sv =====
// ----------------------------------------------------------------------------
// cpobb_recon
// Rebuilds the box point: center plus axis times clamped distance, then
// rounds and saturates. Two stages: products (s4), sum/round/saturate (s5).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpobb_recon import cpobb_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  box_cfg_t                    box,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [DIST_BITS-1:0] clamp_dist [3],
	output logic                        out_valid,
	input  logic                        out_ready,
	output nearest_t                    nearest
);

	logic                        valid_s4, valid_s5;
	logic                        en_s4, en_s5;
	logic signed [PROD_BITS-1:0] prod_s4 [3][3];
	nearest_t                    nearest_s5;

	logic signed [ACC_BITS-1:0]   acc [3];
	logic signed [RND_BITS-1:0]   rnd [3];
	logic signed [COORD_BITS-1:0] sat [3];

	assign en_s5    = !valid_s5 || out_ready;
	assign en_s4    = !valid_s4 || en_s5;
	assign in_ready = en_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en_s4)
				valid_s4 <= in_valid;
			if (en_s5)
				valid_s5 <= valid_s4;
		end
	end

	// prod_s4[j][i]: component j of axis i times distance i
	always_ff @(posedge clk) begin
		if (en_s4 && in_valid) begin
			for (int j = 0; j < 3; j++) begin
				for (int i = 0; i < 3; i++) begin
					prod_s4[j][i] <= $signed(box.axis[i][j]) * clamp_dist[i];
				end
			end
		end
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			acc[j] = (ACC_BITS'($signed(box.center[j])) <<< AXIS_FRAC)
				+ ACC_BITS'(prod_s4[j][0]) + ACC_BITS'(prod_s4[j][1])
				+ ACC_BITS'(prod_s4[j][2]);
			rnd[j] = round_frac(acc[j]);
			if (rnd[j] > COORD_MAX) begin
				sat[j] = COORD_MAX[COORD_BITS-1:0];
			end else if (rnd[j] < COORD_MIN) begin
				sat[j] = COORD_MIN[COORD_BITS-1:0];
			end else begin
				sat[j] = rnd[j][COORD_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && valid_s4) begin
			nearest_s5.nearest_x <= sat[0];
			nearest_s5.nearest_y <= sat[1];
			nearest_s5.nearest_z <= sat[2];
		end
	end

	assign out_valid = valid_s5;
	assign nearest   = nearest_s5;

	// a stalled product stage keeps its word
	`ASSERT_CLK(a_recon_s4_hold, valid_s4 && !en_s4 |=> valid_s4 && $stable(prod_s4[0][0]))

endmodule

// ===== hw/rtl/closest_point_on_obb_unit.sv =====
// ----------------------------------------------------------------------------
// closest_point_on_obb_unit
// Nearest point on a configured oriented box to a stream of 3D points.
// ----------------------------------------------------------------------------
//  channel   | signals                               | dir | word
//  ----------+---------------------------------------+-----+-------------------
//  point     | point_valid, point_ready, point       | in  | x, y, z Q8.12
//  nearest   | nearest_valid, nearest_ready, nearest | out | x, y, z Q8.12 sat
//  cfg       | cfg_valid, cfg_ready, cfg_index/data  | in  | box register write
//
//  One word per clock sustained while nearest_ready is high; five stages
//  (offset, two multiply stages each followed by a sum/round stage).
//  nearest_valid rises once the word has passed registers s1 through s5.
//  Every stage holds its word while the next is full; ready ripples back
//  through the five stage enables, so empty stages keep filling under a stall.
//  Reset clears all stage valids and the box registers to zero.
//  cfg_ready is always high; writes are registered into the box registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module closest_point_on_obb_unit import cpobb_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     point_valid,
	output logic                     point_ready,
	input  point_t                   point,
	output logic                     nearest_valid,
	input  logic                     nearest_ready,
	output nearest_t                 nearest,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	box_cfg_t                    box_q;
	logic                        valid_s1;
	logic                        en_s1;
	logic signed [DIFF_BITS-1:0] diff_s1 [3];
	logic signed [COORD_BITS-1:0] pt [3];

	logic                        proj_ready;
	logic                        proj_valid;
	logic                        recon_ready;
	logic signed [DIST_BITS-1:0] clamp_dist [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BOX_CENTER: box_q.center  <= cfg_data;
				REG_HALF_EXT:   box_q.half    <= cfg_data;
				REG_AXIS_ZERO:  box_q.axis[0] <= cfg_data[3*AXIS_BITS-1:0];
				REG_AXIS_ONE:   box_q.axis[1] <= cfg_data[3*AXIS_BITS-1:0];
				REG_AXIS_TWO:   box_q.axis[2] <= cfg_data[3*AXIS_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign pt[0] = point.point_x;
	assign pt[1] = point.point_y;
	assign pt[2] = point.point_z;

	assign en_s1       = !valid_s1 || proj_ready;
	assign point_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= point_valid;
		end
	end

	// offset from box center, kept exact
	always_ff @(posedge clk) begin
		if (en_s1 && point_valid) begin
			for (int j = 0; j < 3; j++) begin
				diff_s1[j] <= DIFF_BITS'(pt[j]) - DIFF_BITS'($signed(box_q.center[j]));
			end
		end
	end

	cpobb_proj u_proj (
		.clk        (clk),
		.arst_n     (arst_n),
		.box        (box_q),
		.in_valid   (valid_s1),
		.in_ready   (proj_ready),
		.diff       (diff_s1),
		.out_valid  (proj_valid),
		.out_ready  (recon_ready),
		.clamp_dist (clamp_dist)
	);

	cpobb_recon u_recon (
		.clk        (clk),
		.arst_n     (arst_n),
		.box        (box_q),
		.in_valid   (proj_valid),
		.in_ready   (recon_ready),
		.clamp_dist (clamp_dist),
		.out_valid  (nearest_valid),
		.out_ready  (nearest_ready),
		.nearest    (nearest)
	);

	// with the output empty the whole pipe drains forward, so input is open
	`ASSERT_CLK(a_top_open, !nearest_valid |-> point_ready)

endmodule
